@@ hdl/top_four_peak_finder_macros.svh @@
// assertion helpers for the asserting top-level file
`ifndef TOP_FOUR_PEAK_FINDER_MACROS_SVH
`define TOP_FOUR_PEAK_FINDER_MACROS_SVH

// same-cycle implication, held off during reset
`define TFP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("peak finder check failed");

// next-cycle implication, held off during reset
`define TFP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("peak finder check failed");

`endif

@@ hdl/tfp_pkg.sv @@
`default_nettype none
package tfp_pkg;

  localparam int SEP_W = 10;
  localparam int AMP_W = 16;
  localparam logic [SEP_W-1:0] SEP_RESET = 10'd8;

  localparam int DEF_MAX_SAMPLES = 1024;
  localparam int DEF_NUM_PEAKS = 4;

  // rank field keeps at least one bit
  function automatic int rank_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage
`default_nettype wire

@@ hdl/tfp_ram.sv @@
`default_nettype none
module tfp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/tfp_loader.sv @@
`default_nettype none
module tfp_loader
  import tfp_pkg::*;
#(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [AMP_W-1:0]                   in_sample,
  input  wire logic                               in_last,
  output logic                                    ram_we,
  output logic      [$clog2(MAX_SAMPLES):0]       ram_waddr,
  output logic      [AMP_W-1:0]                   ram_wdata,
  output logic                                    job_push,
  output logic                                    job_bank,
  output logic      [$clog2(MAX_SAMPLES):0]       job_count,
  input  wire logic                               job_full,
  input  wire logic                               release_valid,
  input  wire logic                               release_bank
);

  localparam int PW = $clog2(MAX_SAMPLES);
  localparam int CW = PW + 1;

  logic          wr_bank, wr_bank_next;
  logic [CW-1:0] count, count_next;
  logic [1:0]    busy, busy_next;
  logic          accept;
  logic          store;

  assign in_ready  = !busy[wr_bank] && !job_full;
  assign accept    = in_valid && in_ready;
  // beats past the end of the buffer are dropped but still count for the last mark
  assign store     = accept && (count < CW'(MAX_SAMPLES));
  assign ram_we    = store;
  assign ram_waddr = {wr_bank, count[PW-1:0]};
  assign ram_wdata = in_sample;
  assign job_push  = accept && in_last;
  assign job_bank  = wr_bank;
  assign job_count = store ? count + CW'(1) : count;

  always_comb begin
    wr_bank_next = wr_bank;
    count_next   = count;
    busy_next    = busy;
    if (release_valid) begin
      busy_next[release_bank] = 1'b0;
    end
    if (store) begin
      count_next = count + CW'(1);
    end
    if (job_push) begin
      busy_next[wr_bank] = 1'b1;
      wr_bank_next       = !wr_bank;
      count_next         = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_bank <= 1'b0;
      count   <= '0;
      busy    <= '0;
    end else begin
      wr_bank <= wr_bank_next;
      count   <= count_next;
      busy    <= busy_next;
    end
  end

endmodule
`default_nettype wire

@@ hdl/tfp_job_fifo.sv @@
`default_nettype none
module tfp_job_fifo #(
  parameter int WIDTH = 12
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  valid
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == 2'd2);
  assign valid   = (fill != 2'd0);
  assign dout    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

@@ hdl/tfp_scanner.sv @@
`default_nettype none
module tfp_scanner
  import tfp_pkg::*;
#(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int NUM_PEAKS   = DEF_NUM_PEAKS
) (
  input  wire logic                                                clk,
  input  wire logic                                                rst,
  input  wire logic [SEP_W-1:0]                                    min_separation,
  input  wire logic                                                job_valid,
  input  wire logic                                                job_bank,
  input  wire logic [$clog2(MAX_SAMPLES):0]                        job_count,
  output logic                                                     job_pop,
  output logic      [$clog2(MAX_SAMPLES):0]                        ram_raddr,
  input  wire logic [AMP_W-1:0]                                    ram_rdata,
  output logic                                                     release_valid,
  output logic                                                     release_bank,
  input  wire logic                                                emit_busy,
  output logic                                                     emit_load,
  output logic      [NUM_PEAKS-1:0][$clog2(MAX_SAMPLES)-1:0]       list_pos,
  output logic      [NUM_PEAKS-1:0][AMP_W-1:0]                     list_amp
);

  localparam int PW = $clog2(MAX_SAMPLES);
  localparam int CW = PW + 1;
  localparam int SW = ((CW > SEP_W) ? CW : SEP_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CUR,
    S_LOOK,
    S_INSERT,
    S_HAND
  } state_t;

  state_t                         state, state_next;
  logic                           bank, bank_next;
  logic [CW-1:0]                  count, count_next;
  logic [PW-1:0]                  cur, cur_next;
  logic [AMP_W-1:0]               cur_val, cur_val_next;
  logic [PW-1:0]                  k, k_next;
  logic [NUM_PEAKS-1:0][PW-1:0]   best_pos, best_pos_next;
  logic [NUM_PEAKS-1:0][AMP_W-1:0] best_amp, best_amp_next;

  logic [PW-1:0]                  rd_pos;
  logic                           rd_bank;
  logic [PW:0]                    k1;
  logic [SW-1:0]                  sep_ext;
  logic [SW-1:0]                  cnt_ext;
  logic [SW-1:0]                  cur_plus1;
  logic [SW-1:0]                  cur_end;
  logic [SW-1:0]                  k_plus1;
  logic [SW-1:0]                  k_end;
  logic [SW-1:0]                  jump_pos;
  logic [NUM_PEAKS-1:0]           hit;
  logic [NUM_PEAKS-1:0][PW-1:0]   ins_pos;
  logic [NUM_PEAKS-1:0][AMP_W-1:0] ins_amp;

  assign sep_ext   = SW'(min_separation);
  assign cnt_ext   = SW'(count);
  assign cur_plus1 = SW'(cur) + SW'(1);
  assign cur_end   = SW'(cur) + sep_ext;
  assign k_plus1   = SW'(k) + SW'(1);
  // window end if the sample at k takes over as the current one
  assign k_end     = SW'(k) + sep_ext;
  assign jump_pos  = cur_end + SW'(1);
  assign k1        = {1'b0, k} + (PW+1)'(1);

  assign ram_raddr     = {rd_bank, rd_pos};
  assign release_bank  = bank;
  assign list_pos      = best_pos;
  assign list_amp      = best_amp;

  // descending list: a hit run covers the tail from the insertion slot on
  always_comb begin
    for (int j = 0; j < NUM_PEAKS; j++) begin
      hit[j] = cur_val > best_amp[j];
    end
    for (int j = 0; j < NUM_PEAKS; j++) begin
      if (!hit[j]) begin
        ins_pos[j] = best_pos[j];
        ins_amp[j] = best_amp[j];
      end else if (j == 0) begin
        ins_pos[j] = cur;
        ins_amp[j] = cur_val;
      end else if (!hit[j-1]) begin
        ins_pos[j] = cur;
        ins_amp[j] = cur_val;
      end else begin
        ins_pos[j] = best_pos[j-1];
        ins_amp[j] = best_amp[j-1];
      end
    end
  end

  always_comb begin
    state_next    = state;
    bank_next     = bank;
    count_next    = count;
    cur_next      = cur;
    cur_val_next  = cur_val;
    k_next        = k;
    best_pos_next = best_pos;
    best_amp_next = best_amp;
    rd_pos        = k1[PW-1:0];
    rd_bank       = bank;
    job_pop       = 1'b0;
    release_valid = 1'b0;
    emit_load     = 1'b0;

    case (state)
      S_IDLE: begin
        rd_pos  = '0;
        rd_bank = job_bank;
        if (job_valid) begin
          job_pop       = 1'b1;
          bank_next     = job_bank;
          count_next    = job_count;
          cur_next      = '0;
          best_pos_next = '0;
          best_amp_next = '0;
          state_next    = S_CUR;
        end
      end
      S_CUR: begin
        cur_val_next = ram_rdata;
        rd_pos       = cur_plus1[PW-1:0];
        k_next       = cur_plus1[PW-1:0];
        if ((cur_plus1 >= cur_end) || (cur_plus1 >= cnt_ext)) begin
          state_next = S_INSERT;
        end else begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        // read for k+1 goes out while the sample at k is compared
        k_next = k1[PW-1:0];
        if (ram_rdata > cur_val) begin
          cur_next     = k;
          cur_val_next = ram_rdata;
          if ((k_plus1 >= k_end) || (k_plus1 >= cnt_ext)) begin
            state_next = S_INSERT;
          end
        end else if ((k_plus1 >= cur_end) || (k_plus1 >= cnt_ext)) begin
          state_next = S_INSERT;
        end
      end
      S_INSERT: begin
        if (|hit) begin
          best_pos_next = ins_pos;
          best_amp_next = ins_amp;
          rd_pos        = jump_pos[PW-1:0];
          cur_next      = jump_pos[PW-1:0];
          state_next    = (jump_pos >= cnt_ext) ? S_HAND : S_CUR;
        end else begin
          rd_pos     = cur_plus1[PW-1:0];
          cur_next   = cur_plus1[PW-1:0];
          state_next = (cur_plus1 >= cnt_ext) ? S_HAND : S_CUR;
        end
      end
      S_HAND: begin
        if (!emit_busy) begin
          emit_load     = 1'b1;
          release_valid = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    bank     <= bank_next;
    count    <= count_next;
    cur      <= cur_next;
    cur_val  <= cur_val_next;
    k        <= k_next;
    best_pos <= best_pos_next;
    best_amp <= best_amp_next;
  end

endmodule
`default_nettype wire

@@ hdl/tfp_emitter.sv @@
`default_nettype none
module tfp_emitter
  import tfp_pkg::*;
#(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int NUM_PEAKS   = DEF_NUM_PEAKS,
  parameter int OUT_W       = 32
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          load,
  input  wire logic [NUM_PEAKS-1:0][$clog2(MAX_SAMPLES)-1:0] load_pos,
  input  wire logic [NUM_PEAKS-1:0][AMP_W-1:0]               load_amp,
  output logic                                               busy,
  output logic                                               out_valid,
  input  wire logic                                          out_ready,
  output logic      [OUT_W-1:0]                              out_data,
  output logic                                               out_last
);

  localparam int PW = $clog2(MAX_SAMPLES);
  localparam int RW = rank_width(NUM_PEAKS);

  logic [NUM_PEAKS-1:0][PW-1:0]    pos_buf;
  logic [NUM_PEAKS-1:0][AMP_W-1:0] amp_buf;
  logic [RW-1:0]                   rank;
  logic                            valid;

  assign busy      = valid;
  assign out_valid = valid;
  assign out_last  = (rank == RW'(NUM_PEAKS - 1));
  assign out_data  = OUT_W'({rank, amp_buf[rank], pos_buf[rank]});

  always_ff @(posedge clk) begin
    if (load) begin
      pos_buf <= load_pos;
      amp_buf <= load_amp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (load) begin
      valid <= 1'b1;
      rank  <= '0;
    end else if (valid && out_ready) begin
      if (out_last) begin
        valid <= 1'b0;
      end else begin
        rank <= rank + RW'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/top_four_peak_finder.sv @@
`default_nettype none
`include "top_four_peak_finder_macros.svh"
// Top-four peak finder. Samples of one record come in one beat per cycle and are
// written to one of two buffer banks; the beat with tlast closes the record and
// queues it for scanning, and the next record may load into the other bank while
// the scan runs. Input stalls only while both banks hold records that have not yet
// been scanned and handed to the output. The scan reads one buffered sample per
// cycle through the single read port of the buffer: each candidate is read, its
// look-ahead window is checked, and it is tried against the list. A candidate
// that enters the list moves the scan past its window, but one that does not
// restarts the look-ahead one position on, so a sample may be read again for
// each candidate whose window covers it. Then NUM_PEAKS result beats follow,
// rank 0 (largest) first, tlast on the final one; slots with no peak read as zero.
// min_separation may only be written while no record is in flight.
module top_four_peak_finder
  import tfp_pkg::*;
#(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int NUM_PEAKS   = DEF_NUM_PEAKS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [SEP_W-1:0] cfg_data,       // min_separation
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [AMP_W-1:0] s_axis_tdata,   // sample
  input  wire logic             s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [((($clog2(MAX_SAMPLES) + AMP_W + rank_width(NUM_PEAKS)) + 7) / 8) * 8 - 1:0]
                                m_axis_tdata,   // peak_index, peak_amplitude, peak_rank
  output logic                  m_axis_tlast
);

  localparam int PW    = $clog2(MAX_SAMPLES);
  localparam int CW    = PW + 1;
  localparam int RW    = rank_width(NUM_PEAKS);
  localparam int OUT_W = ((PW + AMP_W + RW + 7) / 8) * 8;
  localparam int RAM_DEPTH = 2 * (1 << PW);

  logic [SEP_W-1:0] min_separation;

  logic                              ram_we;
  logic [PW:0]                       ram_waddr;
  logic [AMP_W-1:0]                  ram_wdata;
  logic [PW:0]                       ram_raddr;
  logic [AMP_W-1:0]                  ram_rdata;

  logic                              job_push;
  logic                              job_bank;
  logic [CW-1:0]                     job_count;
  logic                              job_full;
  logic                              job_pop;
  logic                              job_valid;
  logic [CW:0]                       job_dout;

  logic                              release_valid;
  logic                              release_bank;
  logic                              emit_busy;
  logic                              emit_load;
  logic [NUM_PEAKS-1:0][PW-1:0]      list_pos;
  logic [NUM_PEAKS-1:0][AMP_W-1:0]   list_amp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_separation <= SEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_separation <= cfg_data;
    end
  end

  tfp_loader #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_loader (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_sample     (s_axis_tdata),
    .in_last       (s_axis_tlast),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .job_push      (job_push),
    .job_bank      (job_bank),
    .job_count     (job_count),
    .job_full      (job_full),
    .release_valid (release_valid),
    .release_bank  (release_bank)
  );

  tfp_ram #(
    .WIDTH (AMP_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tfp_job_fifo #(
    .WIDTH (CW + 1)
  ) u_job_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   ({job_bank, job_count}),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (job_dout),
    .valid (job_valid)
  );

  tfp_scanner #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .NUM_PEAKS   (NUM_PEAKS)
  ) u_scanner (
    .clk            (clk),
    .rst            (rst),
    .min_separation (min_separation),
    .job_valid      (job_valid),
    .job_bank       (job_dout[CW]),
    .job_count      (job_dout[CW-1:0]),
    .job_pop        (job_pop),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .release_valid  (release_valid),
    .release_bank   (release_bank),
    .emit_busy      (emit_busy),
    .emit_load      (emit_load),
    .list_pos       (list_pos),
    .list_amp       (list_amp)
  );

  tfp_emitter #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .NUM_PEAKS   (NUM_PEAKS),
    .OUT_W       (OUT_W)
  ) u_emitter (
    .clk       (clk),
    .rst       (rst),
    .load      (emit_load),
    .load_pos  (list_pos),
    .load_amp  (list_amp),
    .busy      (emit_busy),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

  // a closed record always finds room in the queue
  `TFP_ASSERT_IMP(a_job_no_overflow, clk, rst, job_push, !job_full)
  // an empty slot never carries a position
  `TFP_ASSERT_IMP(a_empty_slot_zero, clk, rst,
    m_axis_tvalid && (m_axis_tdata[PW +: AMP_W] == '0), m_axis_tdata[PW-1:0] == '0)
  // tlast only on the lowest-ranked slot
  `TFP_ASSERT_IMP(a_last_rank, clk, rst, m_axis_tvalid && m_axis_tlast,
    m_axis_tdata[PW + AMP_W +: RW] == RW'(NUM_PEAKS - 1))
  // the beats of one result set follow without a gap
  `TFP_ASSERT_NXT(a_beats_back_to_back, clk, rst,
    m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)

endmodule
`default_nettype wire
